### hw/rtl/cdm_pkg.sv
// shared types, constants and frame helpers for the cia 402 drive manager
package cdm_pkg;

    // configuration register indexes
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] REG_NODE_ID      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_POS_LIMIT    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PROFILE_VEL  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ACCELERATION = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_DRIVE_ENABLE = 3'd4;

    localparam int QUEUE_DEPTH_DEF = 2;

    // frame identifier bases
    localparam logic [10:0] BASE_TX     = 11'h600;
    localparam logic [10:0] BASE_SDO_RX = 11'h580;
    localparam logic [10:0] BASE_POS    = 11'h280;
    localparam logic [10:0] BASE_EMCY   = 11'h080;

    localparam logic [7:0] SDO_WR_CMD    = 8'h23;
    localparam logic [7:0] SDO_READ_CMD  = 8'h40;
    localparam logic [7:0] SDO_FREE_MASK = 8'h1E;

    localparam logic [15:0] MASK_NARROW = 16'b0000000001001111;
    localparam logic [15:0] MASK_WIDE   = 16'b0000000001101111;

    localparam logic [15:0] CW_MODE_ABSOLUTE = 16'b00101111;
    localparam logic [15:0] CW_TRIGGER       = 16'b00010000;
    localparam logic [15:0] CW_FAULT_RESET   = 16'b10000000;
    localparam logic [15:0] CW_SHUTDOWN      = 16'h0006;
    localparam logic [15:0] CW_SWITCH_ON     = 16'h0007;
    localparam logic [15:0] CW_ENABLE_OP     = 16'h000F;

    localparam logic [15:0] OBJ_CONTROL = 16'h6040;
    localparam logic [15:0] OBJ_STATUS  = 16'h6041;
    localparam logic [15:0] OBJ_TARGET  = 16'h607A;

    // drive states
    localparam logic [2:0] ST_NOT_READY   = 3'd0;
    localparam logic [2:0] ST_DISABLED    = 3'd1;
    localparam logic [2:0] ST_READY       = 3'd2;
    localparam logic [2:0] ST_SWITCHED_ON = 3'd3;
    localparam logic [2:0] ST_ENABLED     = 3'd4;
    localparam logic [2:0] ST_QUICK_STOP  = 3'd5;
    localparam logic [2:0] ST_FAULT_REACT = 3'd6;
    localparam logic [2:0] ST_FAULT       = 3'd7;

    // item kinds
    localparam logic [1:0] CMD_FRAME    = 2'd0;
    localparam logic [1:0] CMD_POSITION = 2'd1;
    localparam logic [1:0] CMD_POLL     = 2'd2;

    // status word decode, tried from the first row
    localparam logic [15:0] DEC_MASK [8] = '{
        MASK_NARROW, MASK_WIDE, MASK_NARROW, MASK_NARROW,
        MASK_WIDE, MASK_WIDE, MASK_WIDE, MASK_NARROW
    };
    localparam logic [15:0] DEC_VALUE [8] = '{
        16'h00, 16'h07, 16'h08, 16'h0F, 16'h21, 16'h23, 16'h27, 16'h40
    };
    localparam logic [2:0] DEC_CODE [8] = '{
        ST_NOT_READY, ST_QUICK_STOP, ST_FAULT, ST_FAULT_REACT,
        ST_READY, ST_SWITCHED_ON, ST_ENABLED, ST_DISABLED
    };

    localparam logic [15:0] PROFILE_OBJ [6] = '{
        16'h6081, 16'h6083, 16'h6084, 16'h6085, 16'h60C5, 16'h60C6
    };

    typedef enum logic [2:0] {
        JOB_NONE,
        JOB_FAULT_RST,
        JOB_READY_ON,
        JOB_SHUTDOWN,
        JOB_SWITCH_ON,
        JOB_POSITION,
        JOB_POLL
    } job_kind_t;

    typedef struct packed {
        logic [6:0]  node_id;
        logic [30:0] pos_limit;
        logic [31:0] prof_speed;
        logic [31:0] acceleration;
        logic        drive_enable;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [10:0]        frame_id;
        logic [63:0]        frame_data;
        logic signed [31:0] tgt_pos;
    } in_word_t;

    typedef struct packed {
        logic               tx_valid;
        logic [10:0]        tx_id;
        logic [63:0]        tx_data;
        logic               last;
        logic [2:0]         drive_state;
        logic [15:0]        stat_word;
        logic signed [31:0] actual_position;
        logic               fault_flag;
        logic [15:0]        err_code;
    } out_word_t;

    typedef struct packed {
        logic [2:0]  drive_state;
        logic [15:0] stat_word;
        logic [31:0] position;
        logic        fault;
        logic [15:0] err_code;
    } status_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [31:0] target;
        status_t     status;
    } job_t;

    function automatic logic [2:0] decode_state(input logic [15:0] sw);
        logic [2:0] code;
        code = ST_FAULT;
        // walk from the last row so the first matching row wins
        for (int i = 7; i >= 0; i--) begin
            if ((sw & DEC_MASK[i]) == DEC_VALUE[i]) code = DEC_CODE[i];
        end
        return code;
    endfunction

    function automatic logic [63:0] sdo_wr_frame(input logic [15:0] index, input logic wide,
                                                 input logic [31:0] data);
        logic [7:0]  head;
        logic [31:0] payload;
        head    = wide ? SDO_WR_CMD : (SDO_WR_CMD | ((8'd2 << 2) & SDO_FREE_MASK));
        payload = wide ? data : {16'h0000, data[15:0]};
        return {payload, 8'h00, index, head};
    endfunction

    function automatic logic [2:0] job_len(input job_kind_t kind);
        logic [2:0] len;
        case (kind)
            JOB_SWITCH_ON: len = 3'd7;
            JOB_POSITION:  len = 3'd3;
            default:       len = 3'd1;
        endcase
        return len;
    endfunction

endpackage

### hw/rtl/cdm_front.sv
// front end: accepts words, tracks drive status and classifies the frames to send
module cdm_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  cdm_pkg::cfg_t     cfg,
    input  logic              s_valid,
    output logic              s_ready,
    input  cdm_pkg::in_word_t s_data,
    output logic              job_valid,
    input  logic              job_ready,
    output cdm_pkg::job_t     job
);
    import cdm_pkg::*;

    logic [2:0]  drive_state_reg, drive_state_next;
    logic [15:0] stat_word_reg, stat_word_next;
    logic [31:0] position_reg, position_next;
    logic [15:0] err_code_reg, err_code_next;

    logic [10:0]        id_emcy, id_pos, id_sdo;
    logic               fault;
    logic [2:0]         dec_state;
    logic signed [31:0] lim, clamped;
    job_kind_t          kind;

    assign s_ready   = job_ready;
    assign job_valid = s_valid;

    assign id_emcy = BASE_EMCY + {4'b0000, cfg.node_id};
    assign id_pos  = BASE_POS + {4'b0000, cfg.node_id};
    assign id_sdo  = BASE_SDO_RX + {4'b0000, cfg.node_id};

    assign dec_state = decode_state(s_data.frame_data[47:32]);
    assign lim       = signed'({1'b0, cfg.pos_limit});

    always_comb begin
        if (s_data.tgt_pos > lim) begin
            clamped = lim;
        end else if (s_data.tgt_pos < -lim) begin
            clamped = -lim;
        end else begin
            clamped = s_data.tgt_pos;
        end
    end

    always_comb begin
        drive_state_next = drive_state_reg;
        stat_word_next   = stat_word_reg;
        position_next    = position_reg;
        err_code_next    = err_code_reg;
        fault            = 1'b0;
        kind             = JOB_NONE;
        case (s_data.cmd)
            CMD_FRAME: begin
                if (s_data.frame_id == id_emcy) begin
                    err_code_next = s_data.frame_data[15:0];
                    fault         = 1'b1;
                end else if (s_data.frame_id == id_pos) begin
                    position_next = s_data.frame_data[31:0];
                end else if (s_data.frame_id == id_sdo &&
                             s_data.frame_data[23:8] == OBJ_STATUS) begin
                    stat_word_next   = s_data.frame_data[47:32];
                    drive_state_next = dec_state;
                    if (dec_state == ST_FAULT) begin
                        fault = 1'b1;
                        if (err_code_reg == 16'h0000) err_code_next = 16'h0001;
                        if (cfg.drive_enable) kind = JOB_FAULT_RST;
                    end else begin
                        err_code_next = 16'h0000;
                        if (dec_state == ST_READY && cfg.drive_enable) begin
                            kind = JOB_READY_ON;
                        end else if (dec_state == ST_SWITCHED_ON && cfg.drive_enable) begin
                            kind = JOB_SWITCH_ON;
                        end else if (!cfg.drive_enable && dec_state != ST_READY) begin
                            kind = JOB_SHUTDOWN;
                        end
                    end
                end
            end
            CMD_POSITION: begin
                if (drive_state_reg == ST_ENABLED) kind = JOB_POSITION;
            end
            CMD_POLL: begin
                kind = JOB_POLL;
            end
            default: begin
                kind = JOB_NONE;
            end
        endcase
    end

    always_comb begin
        job.kind               = kind;
        job.target             = clamped;
        job.status.drive_state = drive_state_next;
        job.status.stat_word   = stat_word_next;
        job.status.position    = position_next;
        job.status.fault       = fault;
        job.status.err_code    = err_code_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drive_state_reg <= ST_NOT_READY;
            stat_word_reg   <= '0;
            position_reg    <= '0;
            err_code_reg    <= '0;
        end else if (s_valid && s_ready) begin
            drive_state_reg <= drive_state_next;
            stat_word_reg   <= stat_word_next;
            position_reg    <= position_next;
            err_code_reg    <= err_code_next;
        end
    end

endmodule

### hw/rtl/cdm_queue.sv
// short job queue between the front end and the frame sequencer
module cdm_queue #(
    parameter int DEPTH = cdm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  cdm_pkg::job_t wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output cdm_pkg::job_t rd_data
);
    import cdm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push, pop;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = slots[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (push) slots[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= bump(wr_ptr_reg);
            if (pop) rd_ptr_reg <= bump(rd_ptr_reg);
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### hw/rtl/cdm_back.sv
// back end: expands each job into its frames, one output word per cycle while the output is not stalled
module cdm_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  cdm_pkg::cfg_t      cfg,
    input  logic               job_valid,
    output logic               job_pop,
    input  cdm_pkg::job_t      job,
    output logic               m_valid,
    input  logic               m_ready,
    output cdm_pkg::out_word_t m_data
);
    import cdm_pkg::*;

    logic [2:0] step_reg, step_next;
    logic       m_valid_reg, m_valid_next;
    out_word_t  m_data_reg, m_data_next;
    logic       load, is_last;
    logic [63:0] frame;
    logic [2:0]  prof_idx;

    assign load     = !m_valid_reg || m_ready;
    assign is_last  = (step_reg == job_len(job.kind) - 3'd1);
    assign job_pop  = load && job_valid && is_last;
    assign prof_idx = step_reg - 3'd1;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_comb begin
        frame = '0;
        case (job.kind)
            JOB_FAULT_RST: frame = sdo_wr_frame(OBJ_CONTROL, 1'b0, {16'h0000, CW_FAULT_RESET});
            JOB_READY_ON:  frame = sdo_wr_frame(OBJ_CONTROL, 1'b0, {16'h0000, CW_SWITCH_ON});
            JOB_SHUTDOWN:  frame = sdo_wr_frame(OBJ_CONTROL, 1'b0, {16'h0000, CW_SHUTDOWN});
            JOB_SWITCH_ON: begin
                if (step_reg == 3'd0) begin
                    frame = sdo_wr_frame(OBJ_CONTROL, 1'b0, {16'h0000, CW_ENABLE_OP});
                end else if (step_reg == 3'd1) begin
                    frame = sdo_wr_frame(PROFILE_OBJ[prof_idx], 1'b1, cfg.prof_speed);
                end else begin
                    frame = sdo_wr_frame(PROFILE_OBJ[prof_idx], 1'b1, cfg.acceleration);
                end
            end
            JOB_POSITION: begin
                if (step_reg == 3'd0) begin
                    frame = sdo_wr_frame(OBJ_CONTROL, 1'b0, {16'h0000, CW_MODE_ABSOLUTE});
                end else if (step_reg == 3'd1) begin
                    frame = sdo_wr_frame(OBJ_TARGET, 1'b1, job.target);
                end else begin
                    frame = sdo_wr_frame(OBJ_CONTROL, 1'b0,
                                         {16'h0000, CW_MODE_ABSOLUTE | CW_TRIGGER});
                end
            end
            JOB_POLL: frame = {40'h0, OBJ_STATUS, SDO_READ_CMD};
            default:  frame = '0;
        endcase
    end

    always_comb begin
        step_next    = step_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (load) begin
            m_valid_next = job_valid;
            if (job_valid) begin
                step_next                   = is_last ? 3'd0 : step_reg + 3'd1;
                m_data_next.tx_valid        = (job.kind != JOB_NONE);
                m_data_next.tx_id           = (job.kind != JOB_NONE) ?
                                              BASE_TX + {4'b0000, cfg.node_id} : '0;
                m_data_next.tx_data         = frame;
                m_data_next.last            = is_last;
                m_data_next.drive_state     = job.status.drive_state;
                m_data_next.stat_word       = job.status.stat_word;
                m_data_next.actual_position = job.status.position;
                m_data_next.fault_flag      = job.status.fault;
                m_data_next.err_code        = job.status.err_code;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (!aresetn) begin
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

### hw/rtl/canopen_cia402_drive_manager.sv
// top level of the cia 402 drive manager: config registers, front end, queue, sequencer
//
//  channel   ports                   word
//  input     s_valid s_ready s_data  in_word_t: cmd, frame_id, frame_data, tgt_pos
//  output    m_valid m_ready m_data  out_word_t: one frame (or empty word) per transfer
//  config    cfg_wr_en cfg_addr      cfg_wdata, written at once, no read-back
//
//  the front end takes one input word per cycle while the job queue has room
//  each job leaves as 1 to 7 output words, one per cycle unless the output stalls, set by the frame sequencer:
//  7 for switch-on with profile writes, 3 for a position command, 1 otherwise
//  a stalled output holds its register; the queue lets the front end run ahead
//  reset sets the config registers to their defaults and clears status and queue
module canopen_cia402_drive_manager #(
    parameter int QUEUE_DEPTH = cdm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [cdm_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [31:0]                       cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  cdm_pkg::in_word_t                 s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output cdm_pkg::out_word_t                m_data
);
    import cdm_pkg::*;

    cfg_t cfg_reg;
    job_t front_job, queue_job;
    logic front_valid, queue_wr_ready, queue_valid, queue_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.node_id      <= 7'd112;
            cfg_reg.pos_limit    <= 31'd7500;
            cfg_reg.prof_speed   <= 32'd10000;
            cfg_reg.acceleration <= 32'd2000;
            cfg_reg.drive_enable <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_NODE_ID:      cfg_reg.node_id      <= cfg_wdata[6:0];
                REG_POS_LIMIT:    cfg_reg.pos_limit    <= cfg_wdata[30:0];
                REG_PROFILE_VEL:  cfg_reg.prof_speed   <= cfg_wdata;
                REG_ACCELERATION: cfg_reg.acceleration <= cfg_wdata;
                REG_DRIVE_ENABLE: cfg_reg.drive_enable <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    cdm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .job_valid (front_valid),
        .job_ready (queue_wr_ready),
        .job       (front_job)
    );

    cdm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (front_valid),
        .wr_ready (queue_wr_ready),
        .wr_data  (front_job),
        .rd_valid (queue_valid),
        .rd_ready (queue_pop),
        .rd_data  (queue_job)
    );

    cdm_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .job_valid (queue_valid),
        .job_pop   (queue_pop),
        .job       (queue_job),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // an empty word stands alone for its item
    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.tx_valid) |-> (m_data.last && m_data.tx_id == '0 &&
                                           m_data.tx_data == '0))
        else $error("empty output word not marked last or not zero");

    // every transmitted frame goes to the configured node
    a_tx_id_node: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.tx_valid) |-> (m_data.tx_id == BASE_TX + {4'b0000, cfg_reg.node_id}))
        else $error("frame identifier does not match node");

    // while a multi-frame run stalls mid-way, the queue head must stay put
    a_run_holds_job: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.last) |-> queue_valid)
        else $error("job left the queue before its final word");

endmodule

### tb/sv/tb_canopen_cia402_drive_manager.sv
// testbench for the cia 402 drive manager: directed table, then random words against a predictor
module tb;
    import cdm_pkg::*;

    localparam logic [1:0] CMD_SPARE   = 2'd3;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         HOLD_CYCLES = 250;
    localparam int         PRINT_CAP   = 30;

    typedef struct packed {
        logic       is_reg;
        logic [2:0] reg_idx;
        logic [31:0] reg_val;
        logic       typed;
        in_word_t   stim;
        out_word_t  want;
    } drill_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [31:0]           cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    in_word_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_word_t             m_data;

    // predictor copy of the registers and drive status
    logic [6:0]  node;
    logic [30:0] max_pos;
    logic [31:0] prof_vel;
    logic [31:0] accel;
    logic        drv_en;
    logic [2:0]  dstate;
    logic [15:0] sw_q;
    logic [31:0] pos_q;
    logic [15:0] fc_q;

    out_word_t  due_words [$];
    out_word_t  want_word;
    drill_row_t drill [$];
    int         mismatches;
    int         cycle_count;
    logic       calm;
    logic       hold_req;
    logic       hold_spent;
    int         hold_left;

    canopen_cia402_drive_manager DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP) $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    function automatic out_word_t mk_result(logic v, logic [10:0] id, logic [63:0] d, logic l,
                                            logic [2:0] st, logic [15:0] sw, logic [31:0] pos,
                                            logic f, logic [15:0] fc);
        out_word_t r;
        r.tx_valid        = v;
        r.tx_id           = id;
        r.tx_data         = d;
        r.last            = l;
        r.drive_state     = st;
        r.stat_word       = sw;
        r.actual_position = pos;
        r.fault_flag      = f;
        r.err_code        = fc;
        return r;
    endfunction

    function automatic in_word_t mk_word(logic [1:0] cmd, logic [10:0] id, logic [63:0] data,
                                         logic [31:0] tgt);
        in_word_t w;
        w.cmd        = cmd;
        w.frame_id   = id;
        w.frame_data = data;
        w.tgt_pos    = tgt;
        return w;
    endfunction

    function automatic logic [63:0] status_reply(logic [15:0] sw);
        return {16'h0000, sw, 8'h00, OBJ_STATUS, 8'h4B};
    endfunction

    function automatic logic [63:0] sdo_frame(logic [15:0] obj, logic four_bytes,
                                              logic [31:0] val);
        logic [7:0]  head;
        logic [31:0] body;
        // two-byte writes flag two unused bytes in bits 3:2 of the command byte
        head = four_bytes ? SDO_WR_CMD : (SDO_WR_CMD | 8'h08);
        body = four_bytes ? val : {16'h0000, val[15:0]};
        return {body, 8'h00, obj, head};
    endfunction

    // first matching row wins, fault when none matches
    function automatic logic [2:0] classify(logic [15:0] sw);
        if ((sw & MASK_NARROW) == 16'h00) return ST_NOT_READY;
        if ((sw & MASK_WIDE) == 16'h07) return ST_QUICK_STOP;
        if ((sw & MASK_NARROW) == 16'h08) return ST_FAULT;
        if ((sw & MASK_NARROW) == 16'h0F) return ST_FAULT_REACT;
        if ((sw & MASK_WIDE) == 16'h21) return ST_READY;
        if ((sw & MASK_WIDE) == 16'h23) return ST_SWITCHED_ON;
        if ((sw & MASK_WIDE) == 16'h27) return ST_ENABLED;
        if ((sw & MASK_NARROW) == 16'h40) return ST_DISABLED;
        return ST_FAULT;
    endfunction

    // updates the drive status and queues the words the block owes for one input word
    function automatic int drive_response(in_word_t w);
        logic [63:0] frames [7];
        int          n;
        int          k;
        logic        saw_fault;
        logic [10:0] tx_id;
        longint      tgt;
        longint      lim;
        n = 0;
        saw_fault = 1'b0;
        tx_id = BASE_TX + {4'b0, node};
        case (w.cmd)
            CMD_FRAME: begin
                if (w.frame_id == BASE_EMCY + {4'b0, node}) begin
                    fc_q = w.frame_data[15:0];
                    saw_fault = 1'b1;
                end else if (w.frame_id == BASE_POS + {4'b0, node}) begin
                    pos_q = w.frame_data[31:0];
                end else if (w.frame_id == BASE_SDO_RX + {4'b0, node} &&
                             w.frame_data[23:8] == OBJ_STATUS) begin
                    sw_q = w.frame_data[47:32];
                    dstate = classify(sw_q);
                    if (dstate == ST_FAULT) begin
                        saw_fault = 1'b1;
                        if (fc_q == 16'h0000) fc_q = 16'h0001;
                        if (drv_en) begin
                            frames[n] = sdo_frame(OBJ_CONTROL, 1'b0, {16'h0, CW_FAULT_RESET});
                            n++;
                        end
                    end else begin
                        fc_q = 16'h0000;
                        if (dstate == ST_READY && drv_en) begin
                            frames[n] = sdo_frame(OBJ_CONTROL, 1'b0, {16'h0, CW_SWITCH_ON});
                            n++;
                        end else if (dstate == ST_SWITCHED_ON && drv_en) begin
                            frames[n] = sdo_frame(OBJ_CONTROL, 1'b0, {16'h0, CW_ENABLE_OP});
                            n++;
                            for (k = 0; k < 6; k++) begin
                                frames[n] = sdo_frame(PROFILE_OBJ[k], 1'b1,
                                                      (k == 0) ? prof_vel : accel);
                                n++;
                            end
                        end else if (!drv_en && dstate != ST_READY) begin
                            frames[n] = sdo_frame(OBJ_CONTROL, 1'b0, {16'h0, CW_SHUTDOWN});
                            n++;
                        end
                    end
                end
            end
            CMD_POSITION: begin
                tgt = $signed(w.tgt_pos);
                lim = {33'b0, max_pos};
                if (tgt > lim) tgt = lim;
                if (tgt < -lim) tgt = -lim;
                if (dstate == ST_ENABLED) begin
                    frames[0] = sdo_frame(OBJ_CONTROL, 1'b0, {16'h0, CW_MODE_ABSOLUTE});
                    frames[1] = sdo_frame(OBJ_TARGET, 1'b1, tgt[31:0]);
                    frames[2] = sdo_frame(OBJ_CONTROL, 1'b0,
                                          {16'h0, CW_MODE_ABSOLUTE | CW_TRIGGER});
                    n = 3;
                end
            end
            CMD_POLL: begin
                frames[0] = {40'h0, OBJ_STATUS, SDO_READ_CMD};
                n = 1;
            end
            default: ;
        endcase
        if (n == 0) begin
            due_words.insert(due_words.size(),
                             mk_result(1'b0, 11'h0, 64'h0, 1'b1, dstate, sw_q, pos_q,
                                       saw_fault, fc_q));
        end else begin
            for (k = 0; k < n; k++) begin
                due_words.insert(due_words.size(),
                                 mk_result(1'b1, tx_id, frames[k], k == n - 1, dstate, sw_q,
                                           pos_q, saw_fault, fc_q));
            end
        end
        return (n == 0) ? 1 : n;
    endfunction

    // mostly well-formed traffic for the current node, the rest noise
    function automatic in_word_t random_word();
        in_word_t    w;
        int          pick;
        logic [15:0] sw;
        w = mk_word(CMD_FRAME, 11'($urandom_range(0, 2047)), {$urandom, $urandom}, $urandom);
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            case ($urandom_range(0, 11))
                0, 1, 2, 3: sw = 16'h0027;
                4, 5:       sw = 16'h0021;
                6, 7:       sw = 16'h0023;
                8:          sw = 16'h0000;
                9:          sw = 16'h0040;
                10:         sw = ($urandom_range(0, 1) == 0) ? 16'h0007 : 16'h0008;
                default:    sw = 16'h000F;
            endcase
            // bits outside the decode masks carry no meaning
            sw = sw | (16'($urandom) & ~MASK_WIDE);
            if ($urandom_range(0, 9) == 0) sw = 16'($urandom);
            w.frame_id = BASE_SDO_RX + {4'b0, node};
            w.frame_data[23:8] = OBJ_STATUS;
            w.frame_data[47:32] = sw;
        end else if (pick < 55) begin
            w.cmd = CMD_POSITION;
            case ($urandom_range(0, 4))
                0:       w.tgt_pos = 32'h7FFF_FFFF;
                1:       w.tgt_pos = 32'h8000_0000;
                2:       w.tgt_pos = {1'b0, max_pos};
                3:       w.tgt_pos = $urandom_range(0, 40000) - 20000;
                default: ;
            endcase
        end else if (pick < 63) begin
            w.frame_id = BASE_POS + {4'b0, node};
        end else if (pick < 71) begin
            w.frame_id = BASE_EMCY + {4'b0, node};
        end else if (pick < 81) begin
            w.cmd = CMD_POLL;
        end else if (pick < 86) begin
            w.frame_id = BASE_SDO_RX + {4'b0, node};
        end else if (pick < 90) begin
            w.cmd = CMD_SPARE;
        end
        return w;
    endfunction

    function automatic void add_item(in_word_t w);
        drill_row_t r;
        r = '0;
        r.stim = w;
        drill.insert(drill.size(), r);
    endfunction

    function automatic void add_typed(in_word_t w, out_word_t want);
        drill_row_t r;
        r = '0;
        r.typed = 1'b1;
        r.stim = w;
        r.want = want;
        drill.insert(drill.size(), r);
    endfunction

    function automatic void add_reg(logic [2:0] idx, logic [31:0] val);
        drill_row_t r;
        r = '0;
        r.is_reg = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        drill.insert(drill.size(), r);
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(input in_word_t w, input logic typed, input out_word_t want);
        int gap;
        int n;
        gap = 0;
        if (!calm) begin
            while ($urandom_range(0, 99) < 29) gap++;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        n = drive_response(w);
        if (typed) begin
            repeat (n) void'(due_words.pop_back());
            due_words.insert(due_words.size(), want);
        end
        @(negedge aclk);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (due_words.size() != 0) @(negedge aclk);
    endtask

    task automatic program_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_NODE_ID:      node = val[6:0];
            REG_POS_LIMIT:    max_pos = val[30:0];
            REG_PROFILE_VEL:  prof_vel = val;
            REG_ACCELERATION: accel = val;
            REG_DRIVE_ENABLE: drv_en = val[0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic apply_settings(input logic [31:0] nd, input logic [31:0] mp,
                                  input logic [31:0] pv, input logic [31:0] ac,
                                  input logic [31:0] en);
        settle();
        program_reg(REG_NODE_ID, nd);
        program_reg(REG_POS_LIMIT, mp);
        program_reg(REG_PROFILE_VEL, pv);
        program_reg(REG_ACCELERATION, ac);
        program_reg(REG_DRIVE_ENABLE, en);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_random(input int count);
        repeat (count) send_word(random_word(), 1'b0, '0);
    endtask

    // receiver: random stalls, one long hold-off on request
    initial begin
        m_ready = 1'b0;
        hold_left = 0;
        hold_spent = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (hold_req && !hold_spent) begin
                hold_spent = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= calm || ($urandom_range(0, 99) >= 29);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (due_words.size() == 0) begin
                report_mismatch("result word with nothing expected");
            end else begin
                want_word = due_words.pop_front();
                if (m_data.tx_valid !== want_word.tx_valid)
                    report_mismatch($sformatf("tx_valid got %0b want %0b",
                                              m_data.tx_valid, want_word.tx_valid));
                if (m_data.tx_id !== want_word.tx_id)
                    report_mismatch($sformatf("tx_id got %h want %h",
                                              m_data.tx_id, want_word.tx_id));
                if (m_data.tx_data !== want_word.tx_data)
                    report_mismatch($sformatf("tx_data got %h want %h",
                                              m_data.tx_data, want_word.tx_data));
                if (m_data.last !== want_word.last)
                    report_mismatch($sformatf("last got %0b want %0b",
                                              m_data.last, want_word.last));
                if (m_data.drive_state !== want_word.drive_state)
                    report_mismatch($sformatf("drive_state got %0d want %0d",
                                              m_data.drive_state, want_word.drive_state));
                if (m_data.stat_word !== want_word.stat_word)
                    report_mismatch($sformatf("stat_word got %h want %h",
                                              m_data.stat_word, want_word.stat_word));
                if (m_data.actual_position !== want_word.actual_position)
                    report_mismatch($sformatf("actual_position got %h want %h",
                                              m_data.actual_position,
                                              want_word.actual_position));
                if (m_data.fault_flag !== want_word.fault_flag)
                    report_mismatch($sformatf("fault_flag got %0b want %0b",
                                              m_data.fault_flag, want_word.fault_flag));
                if (m_data.err_code !== want_word.err_code)
                    report_mismatch($sformatf("err_code got %h want %h",
                                              m_data.err_code, want_word.err_code));
            end
        end
    end

    initial begin
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_data    = '0;
        calm      = 1'b0;
        hold_req  = 1'b0;
        mismatches = 0;
        node     = 7'd112;
        max_pos  = 31'd7500;
        prof_vel = 32'd10000;
        accel    = 32'd2000;
        drv_en   = 1'b0;
        dstate   = ST_NOT_READY;
        sw_q     = 16'h0000;
        pos_q    = 32'h0;
        fc_q     = 16'h0000;

        // node 112 after reset: emergency 0x0f0, position 0x2f0, sdo reply 0x5f0, tx 0x670
        add_typed(mk_word(CMD_POLL, 11'h000, 64'h0, 32'h0),
                  mk_result(1'b1, 11'h670, 64'h0000_0000_0060_4140, 1'b1, ST_NOT_READY,
                            16'h0000, 32'h0, 1'b0, 16'h0000));
        add_typed(mk_word(CMD_SPARE, 11'h0F0, '1, '1),
                  mk_result(1'b0, 11'h0, 64'h0, 1'b1, ST_NOT_READY, 16'h0000, 32'h0, 1'b0,
                            16'h0000));
        add_typed(mk_word(CMD_FRAME, 11'h7FF, '1, '1),
                  mk_result(1'b0, 11'h0, 64'h0, 1'b1, ST_NOT_READY, 16'h0000, 32'h0, 1'b0,
                            16'h0000));
        add_typed(mk_word(CMD_FRAME, 11'h2F0, 64'hFFFF_FFFF_8000_0000, 32'h0),
                  mk_result(1'b0, 11'h0, 64'h0, 1'b1, ST_NOT_READY, 16'h0000, 32'h8000_0000,
                            1'b0, 16'h0000));
        add_typed(mk_word(CMD_FRAME, 11'h2F0, 64'h0000_0000_7FFF_FFFF, 32'h0),
                  mk_result(1'b0, 11'h0, 64'h0, 1'b1, ST_NOT_READY, 16'h0000, 32'h7FFF_FFFF,
                            1'b0, 16'h0000));
        add_typed(mk_word(CMD_FRAME, 11'h0F0, 64'h0000_0000_0000_FFFF, 32'h0),
                  mk_result(1'b0, 11'h0, 64'h0, 1'b1, ST_NOT_READY, 16'h0000, 32'h7FFF_FFFF,
                            1'b1, 16'hFFFF));
        // reply for the control word object is not a status
        add_typed(mk_word(CMD_FRAME, 11'h5F0, 64'h0000_0027_0060_404B, 32'h0),
                  mk_result(1'b0, 11'h0, 64'h0, 1'b1, ST_NOT_READY, 16'h0000, 32'h7FFF_FFFF,
                            1'b0, 16'hFFFF));
        add_typed(mk_word(CMD_FRAME, 11'h5F0, status_reply(16'h0000), 32'h0),
                  mk_result(1'b1, 11'h670, 64'h0000_0006_0060_402B, 1'b1, ST_NOT_READY,
                            16'h0000, 32'h7FFF_FFFF, 1'b0, 16'h0000));
        // no mask row matches: fault with a made-up code
        add_typed(mk_word(CMD_FRAME, 11'h5F0, status_reply(16'hFFFF), 32'h0),
                  mk_result(1'b0, 11'h0, 64'h0, 1'b1, ST_FAULT, 16'hFFFF, 32'h7FFF_FFFF,
                            1'b1, 16'h0001));
        add_item(mk_word(CMD_FRAME, 11'h5F0, status_reply(16'h0008), 32'h0));
        add_item(mk_word(CMD_FRAME, 11'h5F0, status_reply(16'h0040), 32'h0));
        add_item(mk_word(CMD_FRAME, 11'h5F0, status_reply(16'h0021), 32'h0));
        add_item(mk_word(CMD_FRAME, 11'h5F0, status_reply(16'h0023), 32'h0));
        add_item(mk_word(CMD_FRAME, 11'h5F0, status_reply(16'h0027), 32'h0));
        add_item(mk_word(CMD_POSITION, 11'h000, 64'h0, 32'h7FFF_FFFF));
        add_item(mk_word(CMD_POSITION, 11'h000, 64'h0, 32'h8000_0000));
        add_item(mk_word(CMD_FRAME, 11'h5F0, status_reply(16'h0007), 32'h0));
        add_item(mk_word(CMD_POSITION, 11'h000, 64'h0, 32'd1234));
        add_item(mk_word(CMD_FRAME, 11'h5F0, status_reply(16'h000F), 32'h0));
        add_reg(REG_DRIVE_ENABLE, 32'd1);
        add_item(mk_word(CMD_FRAME, 11'h5F0, status_reply(16'h0021), 32'h0));
        add_item(mk_word(CMD_FRAME, 11'h5F0, status_reply(16'h0023), 32'h0));
        add_item(mk_word(CMD_FRAME, 11'h0F0, 64'h0000_0000_0000_8130, 32'h0));
        add_item(mk_word(CMD_FRAME, 11'h5F0, status_reply(16'h0008), 32'h0));
        add_item(mk_word(CMD_FRAME, 11'h5F0, status_reply(16'h0027), 32'h0));
        add_item(mk_word(CMD_POSITION, 11'h000, 64'h0, 32'h0));

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (drill[i]) begin
            if (drill[i].is_reg) begin
                settle();
                program_reg(drill[i].reg_idx, drill[i].reg_val);
                cfg_wr_en <= 1'b0;
            end else begin
                send_word(drill[i].stim, drill[i].typed, drill[i].want);
            end
        end

        apply_settings($urandom_range(1, 126), $urandom_range(1, 100000), $urandom, $urandom,
                       32'd1);
        run_random(24);

        // upper bits of the written words must be dropped
        apply_settings(32'd127, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'd1);
        calm = 1'b1;
        run_random(24);
        calm = 1'b0;

        apply_settings(32'hFFFF_FF80, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFE);
        run_random(24);

        apply_settings(32'd1, 32'd7500, $urandom, $urandom, 32'd1);
        run_random(8);
        hold_req = 1'b1;
        run_random(20);

        settle();
        repeat (40) @(negedge aclk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
